// ===== hw/rtl/smse_pkg.sv =====
// Shared types and constants of the stable merge sort engine.
package smse_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             last_item;
  } smse_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [POS_W-1:0] source_index;
    logic             end_of_run;
    logic             overflow;
  } smse_out_t;

  // One stored element: key and arrival position.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } smse_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MERGE,
    ST_DRAIN
  } smse_state_e;

endpackage

// ===== hw/rtl/stable_merge_sort_engine_core.sv =====
// Keys load at one per cycle while the block is idle. After the last key the block runs its
// merge passes, each opened by a setup state, then drains the n results one per cycle.
// Merging moves one element per cycle through the two read ports of the source memory.
// Reset clears the control state only; the two memories hold garbage until loaded.
// The receiver cannot stall: every result is shown for exactly one cycle.
module stable_merge_sort_engine_core
  import smse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  smse_in_t  item_i,
  output logic      result_valid_o,
  output smse_out_t result_o
);

  localparam int unsigned ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W  = CNT_W + 2;

  // Ping-pong stores: each merge pass reads one and writes the other.
  smse_entry_t key_store    [MAX_ITEMS];
  smse_entry_t merge_buffer [MAX_ITEMS];

  smse_entry_t ks_rd0_q, ks_rd1_q, mb_rd0_q, mb_rd1_q;

  smse_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [CNT_W:0]   width_q, width_d;
  logic             src_q, src_d;
  logic [CNT_W-1:0] a_q, a_d, b_q, b_d, mid_q, mid_d, hi_q, hi_d, k_q, k_d;

  smse_entry_t      head0, head1, win;
  logic             take_a;
  logic [CNT_W-1:0] k_inc, a_inc, base, mid_n, hi_n;
  logic [SUM_W-1:0] mid_sum, hi_sum;

  logic              ks_we, mb_we;
  logic [ADDR_W-1:0] ks_waddr, mb_waddr, rd_addr0, rd_addr1;
  smse_entry_t       ks_wdata, mb_wdata;
  logic              accept;

  assign head0  = src_q ? mb_rd0_q : ks_rd0_q;
  assign head1  = src_q ? mb_rd1_q : ks_rd1_q;
  assign take_a = (a_q != mid_q) && ((b_q == hi_q) || (head0.key <= head1.key));
  assign win    = take_a ? head0 : head1;
  assign k_inc  = k_q + CNT_W'(1);
  assign a_inc  = a_q + CNT_W'(1);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Bounds of the next pair of runs, clipped to the set size.
  assign base    = (state_q == ST_SETUP) ? '0 : hi_q;
  assign mid_sum = SUM_W'(base) + SUM_W'(width_q);
  assign hi_sum  = SUM_W'(base) + (SUM_W'(width_q) << 1);
  assign mid_n   = (mid_sum > SUM_W'(cnt_q)) ? cnt_q : CNT_W'(mid_sum);
  assign hi_n    = (hi_sum > SUM_W'(cnt_q)) ? cnt_q : CNT_W'(hi_sum);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    drop_d         = drop_q;
    width_d        = width_q;
    src_d          = src_q;
    a_d            = a_q;
    b_d            = b_q;
    mid_d          = mid_q;
    hi_d           = hi_q;
    k_d            = k_q;
    ks_we          = 1'b0;
    ks_waddr       = cnt_q[ADDR_W-1:0];
    ks_wdata       = '{key: item_i.key_value, pos: POS_W'(cnt_q)};
    mb_we          = 1'b0;
    mb_waddr       = k_q[ADDR_W-1:0];
    mb_wdata       = win;
    result_valid_o = 1'b0;
    result_o       = '{sorted_key: head0.key, source_index: head0.pos,
                       end_of_run: (a_inc == cnt_q), overflow: drop_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q != CNT_W'(MAX_ITEMS)) begin
            ks_we = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (item_i.last_item) begin
            width_d = (CNT_W + 1)'(1);
            src_d   = 1'b0;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        a_d = '0;
        if (SUM_W'(width_q) >= SUM_W'(cnt_q)) begin
          state_d = ST_DRAIN;
        end else begin
          b_d     = mid_n;
          mid_d   = mid_n;
          hi_d    = hi_n;
          k_d     = '0;
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (src_q) begin
          ks_we    = 1'b1;
          ks_waddr = k_q[ADDR_W-1:0];
          ks_wdata = win;
        end else begin
          mb_we = 1'b1;
        end
        if (take_a) a_d = a_inc;
        else        b_d = b_q + CNT_W'(1);
        k_d = k_inc;
        // Pass end: swap stores and double the run width; setup cycle keeps
        // the first read of the new pass clear of this last write.
        if (k_inc == cnt_q) begin
          src_d   = ~src_q;
          width_d = width_q << 1;
          state_d = ST_SETUP;
        end else if (k_inc == hi_q) begin
          a_d   = hi_q;
          b_d   = mid_n;
          mid_d = mid_n;
          hi_d  = hi_n;
        end
      end
      ST_DRAIN: begin
        result_valid_o = 1'b1;
        a_d            = a_inc;
        if (a_inc == cnt_q) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_addr0 = a_d[ADDR_W-1:0];
  assign rd_addr1 = b_d[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      width_q <= '0;
      src_q   <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      width_q <= width_d;
      src_q   <= src_d;
      a_q     <= a_d;
      b_q     <= b_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ks_we) key_store[ks_waddr] <= ks_wdata;
    ks_rd0_q <= key_store[rd_addr0];
    ks_rd1_q <= key_store[rd_addr1];
  end

  always_ff @(posedge clk_i) begin
    if (mb_we) merge_buffer[mb_waddr] <= mb_wdata;
    mb_rd0_q <= merge_buffer[rd_addr0];
    mb_rd1_q <= merge_buffer[rd_addr1];
  end

`ifndef SYNTHESIS
  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.last_item |=> busy && !result_valid_o)
    else $error("last transfer did not start the sort");

  a_end_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.end_of_run |=> !busy)
    else $error("block still busy after final result");

  a_merge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (k_q < cnt_q) && (a_q <= mid_q) && (b_q <= hi_q))
    else $error("merge pointer out of range");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drop_q) |-> $past(cnt_q) == CNT_W'(MAX_ITEMS))
    else $error("key dropped while store not full");
`endif

endmodule
